@@ design/nart_pkg.sv @@
package nart_pkg;

   localparam int REG_COUNT   = 16;
   localparam int SLOT_W      = $clog2(REG_COUNT);
   localparam int TIME_REGS   = 7;
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 8;

   localparam logic [15:0] ADDR_LO = 16'hd5b8;
   localparam logic [15:0] ADDR_HI = 16'hd5b9;

   typedef enum logic [2:0] {
      PHASE_IDLE = 3'b001,
      PHASE_HIGH = 3'b010,
      PHASE_LOW  = 3'b100
   } phase_type;

   typedef enum logic {
      ACC_READ  = 1'b0,
      ACC_WRITE = 1'b1
   } acc_type;

   // packed MSB first, so the seconds sit in the lowest bits as on the bus
   typedef struct packed {
      logic [2:0] weekday;
      logic [7:0] years;
      logic [3:0] month_zero;
      logic [4:0] day_of_month;
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
   } time_type;

   typedef logic [TIME_REGS-1:0][7:0] time_bytes_type;

endpackage

@@ design/nart_time_conv.sv @@
module nart_time_conv (
   input  nart_pkg::time_type       now,
   output nart_pkg::time_bytes_type time_bytes
);
   import nart_pkg::*;

   // v / 10 as (v * 205) >> 11, exact for v below 100
   function automatic logic [7:0] to_bcd(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  tens_x10;
      logic [6:0]  ones;
      prod     = 15'(v) * 15'd205;
      tens     = prod[14:11];
      tens_x10 = {tens, 3'b000} - 7'(0) + {2'b00, tens, 1'b0};
      ones     = v - tens_x10;
      return {tens, ones[3:0]};
   endfunction

   logic [4:0] month_one;
   logic [6:0] year_mod;
   logic [3:0] wd_plus;
   logic [3:0] wd_mod;

   always_comb begin
      month_one = 5'(now.month_zero) + 5'd1;
      if (now.years >= 8'd200) begin
         year_mod = 7'(now.years - 8'd200);
      end else if (now.years >= 8'd100) begin
         year_mod = 7'(now.years - 8'd100);
      end else begin
         year_mod = now.years[6:0];
      end
      wd_plus = 4'(now.weekday) + 4'd2;
      wd_mod  = (wd_plus >= 4'd7) ? wd_plus - 4'd7 : wd_plus;

      time_bytes[0] = to_bcd(7'(now.seconds));
      time_bytes[1] = to_bcd(7'(now.minutes));
      time_bytes[2] = to_bcd(7'(now.hours));
      time_bytes[3] = to_bcd(7'(now.day_of_month));
      time_bytes[4] = to_bcd(7'(month_one));
      time_bytes[5] = to_bcd(year_mod);
      time_bytes[6] = 8'(wd_mod) + 8'd1;
   end

endmodule

@@ design/nibble_access_rtc_registers_core.sv @@
// Clock register block on two bus addresses (0xd5b8, 0xd5b9). Each request word is one bus
// access; each produces exactly one response word: tuser flags whether the address hit the
// block, tdata carries the read byte (zero on writes and misses). A word is taken into an
// input register, and its state update and response are worked out from that register into
// the response register. The block sustains one word per clock while responses are taken;
// stalls on the response side back up through the single input register. All sixteen register
// bytes, the index and the access phase clear on reset; there is no startup sweep.
module nibble_access_rtc_registers_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // bus_address, write_data, time_valid, now_seconds, now_minutes, now_hours,
   // now_day_of_month, now_month_zero, now_years_since_1900, now_weekday, zero pad
   input  logic [nart_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // req_type
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // read_data
   output logic [nart_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // handled
   output logic                               rsp_tuser
);
   import nart_pkg::*;

   logic                           in_valid_ff;
   logic                           in_valid_in;
   logic [REQ_TDATA_W-1:0]         in_data_ff;
   logic                           in_kind_ff;

   phase_type                      phase_ff, phase_in;
   logic [7:0]                     index_ff, index_in;
   logic [REG_COUNT-1:0][7:0]      regs_ff, regs_in;

   logic                           out_valid_ff, out_valid_in;
   logic [7:0]                     out_data_ff;
   logic                           out_hit_ff;

   logic                           advance;
   logic                           hit;
   logic [15:0]                    addr;
   logic [7:0]                     wdata;
   logic                           time_ok;
   time_type                       now;
   time_bytes_type                 time_bytes;
   logic [SLOT_W-1:0]              slot;
   logic [7:0]                     rd;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign addr    = in_data_ff[15:0];
   assign wdata   = in_data_ff[23:16];
   assign time_ok = in_data_ff[24];
   assign now     = time_type'(in_data_ff[61:25]);
   assign hit     = (addr == ADDR_LO) || (addr == ADDR_HI);
   assign slot    = index_ff[SLOT_W-1:0];

   nart_time_conv u_time_conv (
      .now        (now),
      .time_bytes (time_bytes)
   );

   always_comb begin
      phase_in = phase_ff;
      index_in = index_ff;
      regs_in  = regs_ff;
      rd       = '0;
      if (hit) begin
         if (acc_type'(in_kind_ff) == ACC_WRITE) begin
            unique case (phase_ff)
               PHASE_HIGH: begin
                  regs_in[slot] = {wdata[3:0], regs_ff[slot][3:0]};
                  phase_in      = PHASE_LOW;
               end
               PHASE_LOW: begin
                  regs_in[slot] = {regs_ff[slot][7:4], wdata[3:0]};
                  phase_in      = PHASE_IDLE;
               end
               default: begin
                  index_in = wdata;
                  phase_in = PHASE_HIGH;
               end
            endcase
         end else begin
            unique case (phase_ff)
               PHASE_HIGH: begin
                  rd       = {4'h0, regs_ff[slot][7:4]};
                  phase_in = PHASE_LOW;
               end
               PHASE_LOW: begin
                  rd       = {4'h0, regs_ff[slot][3:0]};
                  phase_in = PHASE_IDLE;
               end
               default: begin
                  rd       = index_ff;
                  phase_in = PHASE_IDLE;
                  if (index_ff == 8'd0) begin
                     if (time_ok) begin
                        for (int i = 0; i < TIME_REGS; i++) begin
                           regs_in[i] = time_bytes[i];
                        end
                     end
                  end else begin
                     index_in = index_ff - 8'd1;
                  end
               end
            endcase
         end
      end
   end

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PHASE_IDLE;
         index_ff     <= '0;
         regs_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
            index_ff <= index_in;
            regs_ff  <= regs_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata;
         in_kind_ff <= req_tuser;
      end
      if (advance) begin
         out_data_ff <= rd;
         out_hit_ff  <= hit;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_hit_ff;

`ifndef NO_ASSERTIONS
   a_miss_keeps_state: assert property (@(posedge clock) disable iff (reset)
      advance && !hit |=> $stable(phase_ff) && $stable(index_ff) && $stable(regs_ff))
      else $error("miss changed block state");

   a_idle_write_selects: assert property (@(posedge clock) disable iff (reset)
      advance && hit && in_kind_ff && phase_ff == PHASE_IDLE
      |=> phase_ff == PHASE_HIGH && index_ff == $past(wdata))
      else $error("idle write did not select index");

   a_miss_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("unhandled word carries data");

   a_no_advance_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |=> $stable(phase_ff) && $stable(index_ff))
      else $error("state moved without a word");
`endif

endmodule

@@ bench/tb_top.sv @@
module tb_top;
   import nart_pkg::*;

   localparam int HOLD_CYCLES = 60;
   localparam int IDLE_LIMIT  = 1000;
   localparam int RAND_HITS   = 1200;
   localparam int DIR_N       = 30;

   typedef struct packed {
      logic       hnd;
      logic [7:0] rd;
   } bus_reply_type;

   typedef struct packed {
      acc_type       kind;
      logic [15:0]   addr;
      logic [7:0]    wdata;
      logic          tv;
      time_type      now;
      logic          chk;
      bus_reply_type want;
   } dir_row_type;

   localparam time_type T_ZERO = '0;
   localparam time_type T_MAX  = {3'd6, 8'd255, 4'd11, 5'd31, 5'd23, 6'd59, 6'd59};
   // every field but the years past its legal range
   localparam time_type T_OOR  = {3'd7, 8'd99, 4'd15, 5'd0, 5'd31, 6'd63, 6'd63};

   localparam bus_reply_type R_MISS = '{1'b0, 8'h00};
   localparam bus_reply_type R_ZERO = '{1'b1, 8'h00};

   // want is only used where chk is set
   localparam dir_row_type DIR_ROWS [DIR_N] = '{
      '{ACC_READ,  ADDR_LO,  8'h00, 1'b0, T_MAX,  1'b1, R_ZERO},
      '{ACC_READ,  16'h0000, 8'h00, 1'b1, T_MAX,  1'b1, R_MISS},
      '{ACC_WRITE, 16'hffff, 8'hff, 1'b1, T_MAX,  1'b1, R_MISS},
      '{ACC_READ,  ADDR_HI,  8'h00, 1'b1, T_MAX,  1'b1, R_ZERO},
      '{ACC_WRITE, ADDR_LO,  8'h00, 1'b0, T_ZERO, 1'b1, R_ZERO},
      '{ACC_READ,  16'hd5ba, 8'h00, 1'b0, T_ZERO, 1'b1, R_MISS},
      '{ACC_READ,  ADDR_HI,  8'h00, 1'b0, T_ZERO, 1'b1, '{1'b1, 8'h05}},
      '{ACC_READ,  ADDR_LO,  8'h00, 1'b0, T_ZERO, 1'b1, '{1'b1, 8'h09}},
      '{ACC_WRITE, ADDR_HI,  8'hff, 1'b0, T_ZERO, 1'b1, R_ZERO},
      '{ACC_WRITE, ADDR_LO,  8'ha3, 1'b0, T_ZERO, 1'b1, R_ZERO},
      '{ACC_WRITE, ADDR_HI,  8'h5c, 1'b0, T_ZERO, 1'b1, R_ZERO},
      '{ACC_READ,  ADDR_LO,  8'h00, 1'b1, T_MAX,  1'b1, '{1'b1, 8'hff}},
      '{ACC_WRITE, ADDR_LO,  8'h0f, 1'b0, T_ZERO, 1'b1, R_ZERO},
      '{ACC_READ,  ADDR_HI,  8'h00, 1'b0, T_ZERO, 1'b0, R_MISS},
      '{ACC_WRITE, ADDR_HI,  8'h77, 1'b0, T_ZERO, 1'b1, R_ZERO},
      '{ACC_READ,  ADDR_LO,  8'h00, 1'b0, T_ZERO, 1'b1, '{1'b1, 8'h0f}},
      '{ACC_WRITE, ADDR_LO,  8'h06, 1'b0, T_ZERO, 1'b1, R_ZERO},
      '{ACC_READ,  ADDR_HI,  8'h00, 1'b0, T_ZERO, 1'b0, R_MISS},
      '{ACC_READ,  ADDR_LO,  8'h00, 1'b0, T_ZERO, 1'b0, R_MISS},
      '{ACC_READ,  ADDR_LO,  8'h00, 1'b0, T_ZERO, 1'b1, '{1'b1, 8'h06}},
      '{ACC_WRITE, ADDR_HI,  8'h00, 1'b0, T_ZERO, 1'b1, R_ZERO},
      '{ACC_WRITE, ADDR_LO,  8'h0f, 1'b0, T_ZERO, 1'b1, R_ZERO},
      '{ACC_WRITE, ADDR_LO,  8'hf0, 1'b0, T_ZERO, 1'b1, R_ZERO},
      '{ACC_READ,  ADDR_HI,  8'h00, 1'b1, T_OOR,  1'b1, R_ZERO},
      '{ACC_WRITE, ADDR_LO,  8'h00, 1'b0, T_ZERO, 1'b1, R_ZERO},
      '{ACC_READ,  ADDR_LO,  8'h00, 1'b0, T_ZERO, 1'b0, R_MISS},
      '{ACC_READ,  ADDR_HI,  8'h00, 1'b0, T_ZERO, 1'b0, R_MISS},
      '{ACC_WRITE, ADDR_LO,  8'h04, 1'b0, T_ZERO, 1'b1, R_ZERO},
      '{ACC_READ,  ADDR_LO,  8'h00, 1'b0, T_ZERO, 1'b0, R_MISS},
      '{ACC_READ,  ADDR_LO,  8'h00, 1'b0, T_ZERO, 1'b0, R_MISS}
   };

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;

   // shadow of the register block
   phase_type  nib_phase = PHASE_IDLE;
   logic [7:0] sel_index = '0;
   logic [7:0] rtc_bytes [REG_COUNT] = '{default: '0};

   bus_reply_type owed_replies [$];
   bus_reply_type head_reply;
   int errors      = 0;
   int idle_cycles = 0;
   int block_hits  = 0;
   int hold_asked  = 0;
   int hold_done   = 0;
   bit tx_steady   = 1'b0;
   bit rx_steady   = 1'b0;

   nibble_access_rtc_registers_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   function automatic logic [7:0] bcd_byte(input int unsigned v);
      return 8'((v % 10) | ((v / 10) << 4));
   endfunction

   function automatic int idle_len();
      return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   function automatic logic [15:0] block_addr();
      return $urandom_range(0, 1) ? ADDR_HI : ADDR_LO;
   endfunction

   function automatic logic [7:0] rand_index();
      // small indexes so idle reads count down to zero and latch often
      return ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 20)) : 8'($urandom);
   endfunction

   function automatic time_type rand_now();
      time_type t;
      if ($urandom_range(0, 7) == 0) begin
         t = time_type'(37'({$urandom, $urandom}));
      end else begin
         t.seconds      = 6'($urandom_range(0, 60));
         t.minutes      = 6'($urandom_range(0, 59));
         t.hours        = 5'($urandom_range(0, 23));
         t.day_of_month = 5'($urandom_range(1, 31));
         t.month_zero   = 4'($urandom_range(0, 11));
         t.years        = 8'($urandom_range(0, 255));
         t.weekday      = 3'($urandom_range(0, 6));
      end
      return t;
   endfunction

   task automatic apply_access(input acc_type kind, input logic [15:0] addr,
                               input logic [7:0] wdata, input logic tv, input time_type now,
                               output bus_reply_type reply);
      logic [SLOT_W-1:0] slot;
      slot  = sel_index[SLOT_W-1:0];
      reply = R_MISS;
      if (addr != ADDR_LO && addr != ADDR_HI) return;
      reply.hnd = 1'b1;
      case (nib_phase)
         PHASE_HIGH: begin
            if (kind == ACC_WRITE) rtc_bytes[slot][7:4] = wdata[3:0];
            else reply.rd = {4'h0, rtc_bytes[slot][7:4]};
            nib_phase = PHASE_LOW;
         end
         PHASE_LOW: begin
            if (kind == ACC_WRITE) rtc_bytes[slot][3:0] = wdata[3:0];
            else reply.rd = {4'h0, rtc_bytes[slot][3:0]};
            nib_phase = PHASE_IDLE;
         end
         default: begin
            if (kind == ACC_WRITE) begin
               sel_index = wdata;
               nib_phase = PHASE_HIGH;
            end else begin
               reply.rd = sel_index;
               if (sel_index != 0) begin
                  sel_index = sel_index - 8'd1;
               end else if (tv) begin
                  rtc_bytes[0] = bcd_byte(int'(now.seconds));
                  rtc_bytes[1] = bcd_byte(int'(now.minutes));
                  rtc_bytes[2] = bcd_byte(int'(now.hours));
                  rtc_bytes[3] = bcd_byte(int'(now.day_of_month));
                  rtc_bytes[4] = bcd_byte(int'(now.month_zero) + 1);
                  rtc_bytes[5] = bcd_byte(int'(now.years) % 100);
                  rtc_bytes[6] = 8'(((int'(now.weekday) + 2) % 7) + 1);
               end
            end
         end
      endcase
   endtask

   // valid stays high after acceptance; the next call lowers it only for a gap
   task automatic send_access(input acc_type kind, input logic [15:0] addr,
                              input logic [7:0] wdata, input logic tv, input time_type now,
                              input logic chk, input bus_reply_type want);
      bus_reply_type reply;
      int gap;
      gap = (tx_steady || $urandom_range(0, 2) != 0) ? 0 : idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_TDATA_W'({now, tv, wdata, addr});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_access(kind, addr, wdata, tv, now, reply);
      if (reply.hnd) block_hits++;
      owed_replies.push_back(chk ? want : reply);
   endtask

   task automatic block_word(input acc_type kind, input logic [7:0] wdata);
      send_access(kind, block_addr(), wdata, 1'($urandom), rand_now(), 1'b0, R_MISS);
   endtask

   // receiver
   initial begin
      int stall;
      stall = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else if (hold_done != hold_asked) begin
            hold_done++;
            stall = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (!rx_steady && $urandom_range(0, 4) == 0) begin
            stall = idle_len() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (owed_replies.size() == 0) begin
            $display("%0t unexpected word: handled %0d data %02h", $time, rsp_tuser, rsp_tdata);
            errors++;
         end else begin
            head_reply = owed_replies.pop_front();
            if (rsp_tuser !== head_reply.hnd) begin
               $display("%0t handled: expected %0d got %0d", $time, head_reply.hnd, rsp_tuser);
               errors++;
            end
            if (rsp_tdata !== head_reply.rd) begin
               $display("%0t read_data: expected %02h got %02h", $time, head_reply.rd, rsp_tdata);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int i;
      int n;
      int start_hits;
      bit paused;
      logic [15:0] miss_addr;
      paused = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIR_N; i++) begin
         send_access(DIR_ROWS[i].kind, DIR_ROWS[i].addr, DIR_ROWS[i].wdata, DIR_ROWS[i].tv,
                     DIR_ROWS[i].now, DIR_ROWS[i].chk, DIR_ROWS[i].want);
      end

      start_hits = block_hits;
      while (block_hits - start_hits < RAND_HITS) begin
         if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
         if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
         // long receiver hold-off while words keep coming
         if (block_hits - start_hits >= 400 && hold_asked == 0) hold_asked = 1;
         if (block_hits - start_hits >= 800 && !paused) begin
            paused = 1'b1;
            req_tvalid <= 1'b0;
            do @(posedge clock); while (owed_replies.size() != 0);
         end
         // finish a nibble pair left open, with either kind of access
         while (nib_phase != PHASE_IDLE) block_word(acc_type'($urandom_range(0, 1)), 8'($urandom));
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               block_word(ACC_WRITE, rand_index());
               block_word(ACC_WRITE, 8'($urandom));
               block_word(ACC_WRITE, 8'($urandom));
            end
            3, 4: begin
               block_word(ACC_WRITE, rand_index());
               block_word(ACC_READ, 8'($urandom));
               block_word(ACC_READ, 8'($urandom));
            end
            5, 6: begin
               n = $urandom_range(1, 4);
               repeat (n) send_access(ACC_READ, block_addr(), 8'($urandom),
                                      1'($urandom_range(0, 3) != 0), rand_now(), 1'b0, R_MISS);
            end
            7: begin
               do miss_addr = 16'($urandom); while (miss_addr == ADDR_LO || miss_addr == ADDR_HI);
               send_access(acc_type'($urandom_range(0, 1)), miss_addr, 8'($urandom),
                           1'($urandom), rand_now(), 1'b0, R_MISS);
            end
            8: block_word(acc_type'($urandom_range(0, 1)), 8'($urandom));
            default: begin
               block_word(ACC_WRITE, rand_index());
               block_word(acc_type'($urandom_range(0, 1)), 8'($urandom));
               block_word(acc_type'($urandom_range(0, 1)), 8'($urandom));
            end
         endcase
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (owed_replies.size() != 0);
      repeat (10) @(posedge clock);
      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
